// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hdl/slcfr_pkg.sv =====
`default_nettype none

package slcfr_pkg;

  localparam int PAYLOAD_MAX_DEF = 32;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  function automatic int len_width(int pmax);
    return $clog2(pmax + 1);
  endfunction

  function automatic int idx_width(int pmax);
    return (pmax > 1) ? $clog2(pmax) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/slcfr_ifs.sv =====
`default_nettype none

interface slcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfr_result_if #(
  parameter int LEN_W = 6,
  parameter int IDX_W = 5
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       command;
  logic [LEN_W-1:0] frame_length;
  logic             has_payload;
  logic [7:0]       payload_byte;
  logic [IDX_W-1:0] byte_index;
  logic             last;

  modport source (
    output valid, output status, output command, output frame_length,
    output has_payload, output payload_byte, output byte_index, output last,
    input ready
  );
  modport sink (
    input valid, input status, input command, input frame_length,
    input has_payload, input payload_byte, input byte_index, input last,
    output ready
  );
endinterface

interface slcfr_cfg_if;
  import slcfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/slcfr_ram.sv =====
`default_nettype none

module slcfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sync_len_checksum_frame_receiver.sv =====
// Frame receiver: takes one byte per transfer, hunts for the two sync bytes (registers 0 and
// 1, reset 0xAA and 0xAF), then reads command, length, payload and an 8-bit additive checksum
// over sync, command, length and payload. Payload bytes go into a PAYLOAD_MAX x 8 RAM with
// one write and one registered read port. A good checksum on a frame of N > 0 bytes starts
// a readout of N results through the RAM read port while the byte input is held off, one per
// cycle unless the output is held off; a bad checksum, an oversize length or a zero-length
// frame gives a single result. A byte is taken only while the output register is empty or is
// emptied in the same cycle, so a waiting result holds off the byte input. No clearing pass is
// needed after reset.
`default_nettype none

module sync_len_checksum_frame_receiver #(
  parameter int PAYLOAD_MAX = slcfr_pkg::PAYLOAD_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  slcfr_byte_if.sink      rx,
  slcfr_result_if.source  res,
  slcfr_cfg_if.sink       cfg
);

  import slcfr_pkg::*;
  `include "assert_macros.svh"

  localparam int LEN_W = len_width(PAYLOAD_MAX);
  localparam int IDX_W = idx_width(PAYLOAD_MAX);
  localparam logic [7:0] MAX_BYTE = 8'(PAYLOAD_MAX);

  typedef enum logic [2:0] {
    S_HUNT, S_SYNC, S_CMD, S_LEN, S_DATA, S_CHK, S_DRAIN
  } state_t;

  state_t           state;
  logic [7:0]       sync_first;
  logic [7:0]       sync_second;
  logic [7:0]       frame_command;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] received_count;
  logic [7:0]       running_sum;
  logic [LEN_W-1:0] rd_cnt;
  logic [LEN_W-1:0] rd_idx;
  logic             rd_vld;
  logic [7:0]       rd_data;

  logic rx_fire;
  logic slot_free;
  logic load;
  logic issue;
  logic wr_en;
  logic rd_last;

  assign cfg.ready = 1'b1;

  assign slot_free = !res.valid || res.ready;
  assign rx.ready  = (state != S_DRAIN) && slot_free;
  assign rx_fire   = rx.valid && rx.ready;
  assign load      = rd_vld && slot_free;
  assign issue     = (state == S_DRAIN) && (rd_cnt < frame_len) && (!rd_vld || load);
  assign wr_en     = rx_fire && (state == S_DATA);
  assign rd_last   = (rd_idx + LEN_W'(1)) == frame_len;

  slcfr_ram #(
    .WIDTH  (8),
    .DEPTH  (PAYLOAD_MAX),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (received_count[IDX_W-1:0]),
    .wr_data (rx.rx_byte),
    .rd_en   (issue),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SYNC_FIRST:  sync_first  <= cfg.data;
        CFG_SYNC_SECOND: sync_second <= cfg.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_HUNT;
      res.valid      <= 1'b0;
      rd_vld         <= 1'b0;
      frame_command  <= '0;
      frame_len      <= '0;
      received_count <= '0;
      running_sum    <= '0;
      rd_cnt         <= '0;
      rd_idx         <= '0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end

      // payload readout from the store
      rd_vld <= issue || (rd_vld && !load);
      if (issue) begin
        rd_idx <= rd_cnt;
        rd_cnt <= rd_cnt + LEN_W'(1);
      end
      if (load) begin
        res.valid        <= 1'b1;
        res.status       <= ST_GOOD;
        res.command      <= frame_command;
        res.frame_length <= frame_len;
        res.has_payload  <= 1'b1;
        res.payload_byte <= rd_data;
        res.byte_index   <= rd_idx[IDX_W-1:0];
        res.last         <= rd_last;
        if (rd_last) begin
          state <= S_HUNT;
        end
      end

      if (rx_fire) begin
        unique case (state)
          S_HUNT: begin
            if (rx.rx_byte == sync_first) begin
              state <= S_SYNC;
            end
          end
          S_SYNC: begin
            state <= (rx.rx_byte == sync_second) ? S_CMD : S_HUNT;
          end
          S_CMD: begin
            frame_command <= rx.rx_byte;
            state         <= S_LEN;
          end
          S_LEN: begin
            if (rx.rx_byte > MAX_BYTE) begin
              res.valid        <= 1'b1;
              res.status       <= ST_LEN;
              res.command      <= frame_command;
              res.frame_length <= LEN_W'(PAYLOAD_MAX);
              res.has_payload  <= 1'b0;
              res.payload_byte <= '0;
              res.byte_index   <= '0;
              res.last         <= 1'b1;
              state            <= S_HUNT;
            end else begin
              frame_len      <= rx.rx_byte[LEN_W-1:0];
              received_count <= '0;
              running_sum    <= sync_first + sync_second + frame_command + rx.rx_byte;
              state          <= (rx.rx_byte == 8'd0) ? S_CHK : S_DATA;
            end
          end
          S_DATA: begin
            received_count <= received_count + LEN_W'(1);
            running_sum    <= running_sum + rx.rx_byte;
            if ((received_count + LEN_W'(1)) >= frame_len) begin
              state <= S_CHK;
            end
          end
          S_CHK: begin
            if (running_sum == rx.rx_byte) begin
              if (frame_len == '0) begin
                res.valid        <= 1'b1;
                res.status       <= ST_GOOD;
                res.command      <= frame_command;
                res.frame_length <= '0;
                res.has_payload  <= 1'b0;
                res.payload_byte <= '0;
                res.byte_index   <= '0;
                res.last         <= 1'b1;
                state            <= S_HUNT;
              end else begin
                rd_cnt <= '0;
                state  <= S_DRAIN;
              end
            end else begin
              res.valid        <= 1'b1;
              res.status       <= ST_CSUM;
              res.command      <= frame_command;
              res.frame_length <= frame_len;
              res.has_payload  <= 1'b0;
              res.payload_byte <= '0;
              res.byte_index   <= '0;
              res.last         <= 1'b1;
              state            <= S_HUNT;
            end
          end
          S_DRAIN: begin
          end
        endcase
      end
    end
  end

  // read in flight only during readout
  `ASSERT_CLK(a_rd_in_drain, rd_vld |-> (state == S_DRAIN), "read pending outside readout")
  // no read past the frame length
  `ASSERT_CLK(a_rd_in_range, issue |-> (rd_cnt < frame_len), "read beyond frame length")
  // payload results are always good
  `ASSERT_NEVER(a_payload_good, res.valid && res.has_payload && (res.status != ST_GOOD),
                "payload result with error status")

endmodule

`default_nettype wire

// ===== sim/tb_sync_len_checksum_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_sync_len_checksum_frame_receiver;
  import slcfr_pkg::*;

  localparam int PMAX   = PAYLOAD_MAX_DEF;
  localparam int LEN_W  = len_width(PMAX);
  localparam int IDX_W  = idx_width(PMAX);
  localparam int SETTLE = 2 * PMAX + 8;
  localparam int LIMIT  = 400000;
  localparam int NPHASE = 6;

  typedef enum logic [2:0] {
    RX_HUNT, RX_SYNC, RX_CMD, RX_LEN, RX_DATA, RX_CHK
  } rx_phase_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       command;
    logic [LEN_W-1:0] frame_length;
    logic             has_payload;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last;
  } frame_result_t;

  class frame_tracker;
    logic [7:0]       first_sync;
    logic [7:0]       second_sync;
    rx_phase_t        phase;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
    int               count;
    logic [7:0]       sum;
    logic [7:0]       store [PMAX];
    frame_result_t    pending [$];
    int               errors;

    function new();
      first_sync  = SYNC_FIRST_RST;
      second_sync = SYNC_SECOND_RST;
      phase       = RX_HUNT;
      cmd         = '0;
      len         = '0;
      count       = 0;
      sum         = '0;
      errors      = 0;
    endfunction

    function void set_sync(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_SYNC_FIRST) begin
        first_sync = val;
      end else begin
        second_sync = val;
      end
    endfunction

    function void push(logic [1:0] st, logic [LEN_W-1:0] fl, logic hp, logic [7:0] pb,
                       logic [IDX_W-1:0] bi, logic lst);
      frame_result_t r;
      r.status       = st;
      r.command      = cmd;
      r.frame_length = fl;
      r.has_payload  = hp;
      r.payload_byte = pb;
      r.byte_index   = bi;
      r.last         = lst;
      pending.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        RX_HUNT: begin
          if (b == first_sync) phase = RX_SYNC;
        end
        RX_SYNC: begin
          phase = (b == second_sync) ? RX_CMD : RX_HUNT;
        end
        RX_CMD: begin
          cmd   = b;
          phase = RX_LEN;
        end
        RX_LEN: begin
          if (b > PMAX) begin
            push(ST_LEN, LEN_W'(PMAX), 1'b0, 8'h00, '0, 1'b1);
            phase = RX_HUNT;
          end else begin
            len   = b[LEN_W-1:0];
            count = 0;
            sum   = first_sync + second_sync + cmd + b;
            phase = (b == 8'h00) ? RX_CHK : RX_DATA;
          end
        end
        RX_DATA: begin
          store[count] = b;
          count++;
          sum = sum + b;
          if (count >= len) phase = RX_CHK;
        end
        RX_CHK: begin
          if (sum == b) begin
            if (len == 0) begin
              push(ST_GOOD, '0, 1'b0, 8'h00, '0, 1'b1);
            end else begin
              for (int i = 0; i < len; i++) begin
                push(ST_GOOD, len, 1'b1, store[i], IDX_W'(i), (i + 1 == len));
              end
            end
          end else begin
            push(ST_CSUM, len, 1'b0, 8'h00, '0, 1'b1);
          end
          phase = RX_HUNT;
        end
        default: phase = RX_HUNT;
      endcase
    endfunction

    function void compare_field(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("command", exp_r.command, got.command);
      compare_field("frame_length", exp_r.frame_length, got.frame_length);
      compare_field("has_payload", exp_r.has_payload, got.has_payload);
      compare_field("payload_byte", exp_r.payload_byte, got.payload_byte);
      compare_field("byte_index", exp_r.byte_index, got.byte_index);
      compare_field("last", exp_r.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  slcfr_byte_if rx_if ();
  slcfr_result_if #(.LEN_W(LEN_W), .IDX_W(IDX_W)) res_if ();
  slcfr_cfg_if cfg_if ();

  sync_len_checksum_frame_receiver dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  frame_tracker  frames = new();
  frame_result_t seen;
  logic [7:0]    payload_q [$];
  bit            calm;
  int            frame_bytes;
  int            cycles = 0;

  always #1 clk = ~clk;

  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen.status       = res_if.status;
      seen.command      = res_if.command;
      seen.frame_length = res_if.frame_length;
      seen.has_payload  = res_if.has_payload;
      seen.payload_byte = res_if.payload_byte;
      seen.byte_index   = res_if.byte_index;
      seen.last         = res_if.last;
      frames.check_result(seen);
    end
  end

  // result backpressure
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    frames.take_byte(b);
  endtask

  // bring the receiver back to sync hunting
  task automatic flush_frame();
    while (frames.phase != RX_HUNT) begin
      case (frames.phase)
        RX_SYNC: send_byte(frames.second_sync ^ 8'h01);
        RX_LEN:  send_byte(8'($urandom_range(PMAX + 1, 255)));
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // payload comes from payload_q, its size must match len
  task automatic send_packet(input logic [7:0] cmd, input logic [7:0] len,
                             input logic [7:0] flip);
    logic [7:0] sum;
    flush_frame();
    sum = frames.first_sync + frames.second_sync + cmd + len;
    send_byte(frames.first_sync);
    send_byte(frames.second_sync);
    send_byte(cmd);
    send_byte(len);
    frame_bytes += 4;
    if (len <= PMAX) begin
      foreach (payload_q[i]) begin
        send_byte(payload_q[i]);
        sum = sum + payload_q[i];
      end
      send_byte(sum ^ flip);
      frame_bytes += payload_q.size() + 1;
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (frames.pending.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_syncs(input logic [7:0] a, input logic [7:0] b);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SYNC_FIRST;
    cfg_if.data  <= a;
    do @(posedge clk); while (!cfg_if.ready);
    frames.set_sync(CFG_SYNC_FIRST, a);
    cfg_if.index <= CFG_SYNC_SECOND;
    cfg_if.data  <= b;
    do @(posedge clk); while (!cfg_if.ready);
    frames.set_sync(CFG_SYNC_SECOND, b);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_frame();
    int         pick;
    int         lsel;
    int         n;
    logic [7:0] cmd;
    pick = $urandom_range(0, 99);
    lsel = $urandom_range(0, 9);
    cmd  = 8'($urandom);
    if (lsel == 0) n = 0;
    else if (lsel == 1) n = PMAX;
    else if (lsel == 2) n = $urandom_range(9, PMAX - 1);
    else n = $urandom_range(1, 8);
    payload_q.delete();
    if (pick < 75) begin
      for (int i = 0; i < n; i++) payload_q.push_back(8'($urandom));
      send_packet(cmd, 8'(n), (pick < 60) ? 8'h00 : 8'($urandom_range(1, 255)));
    end else if (pick < 83) begin
      send_packet(cmd, 8'($urandom_range(PMAX + 1, 255)), 8'h00);
    end else if (pick < 91) begin
      // second sync byte broken
      flush_frame();
      send_byte(frames.first_sync);
      send_byte(frames.second_sync ^ 8'($urandom_range(1, 255)));
      frame_bytes += 2;
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
      flush_frame();
    end
  endtask

  initial begin
    logic [7:0] first_set  [NPHASE];
    logic [7:0] second_set [NPHASE];
    first_set  = '{8'h00, 8'hFF, 8'h55, 8'($urandom), 8'hFF, SYNC_FIRST_RST};
    second_set = '{8'hFF, 8'h00, 8'h55, 8'($urandom), 8'hFF, SYNC_SECOND_RST};
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    res_if.ready  <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CFG_SYNC_FIRST;
    cfg_if.data   <= 8'h00;
    calm          = 1'b0;
    frame_bytes   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-length frame
    payload_q.delete();
    send_packet(8'h3C, 8'h00, 8'h00);
    // single byte frame, extreme values
    payload_q = {8'hFF};
    send_packet(8'h00, 8'h01, 8'h00);
    // oversize length
    payload_q.delete();
    send_packet(8'hFF, 8'(PMAX + 1), 8'h00);
    // checksum mismatch
    send_packet(8'h11, 8'h00, 8'h80);
    // wrong second sync, rejected byte not a new first sync
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);

    for (int p = 0; p < NPHASE; p++) begin
      flush_frame();
      drain();
      write_syncs(first_set[p], second_set[p]);
      calm        = (p == 2);
      frame_bytes = 0;
      while (frame_bytes < 32) send_random_frame();
    end

    rx_if.valid <= 1'b0;
    do @(posedge clk); while (frames.pending.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (frames.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, frames.pending.size());
      frames.errors++;
    end
    if (frames.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
